// ===== hw/rtl/ole_pkg.sv =====
// Shared types and constants of the ordered list engine.
package ole_pkg;

  parameter int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DEL_REAR  = 2'd1,
    OP_DEL_FRONT = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic pop_front;
  } store_ctl_t;

endpackage

// ===== hw/rtl/ordered_list_engine_top.sv =====
// Top level of the ordered list engine: sequencer, entry memory and result register.
//
// One command word is taken when start is high and busy is low; each command gives one
// result word, shown for one cycle with out_strobe, the cycle after the command finishes.
// There is no stall on the result side. Deletes, refused commands and inserts at the rear
// finish in the cycle in which they are taken. An insert at position p into a list of n
// entries with p <= n walks the entries behind p through the memory, one per cycle, and
// then writes the item at p. A search reads one entry per cycle from the front, stopping
// at the first match or the last entry. busy is high for all but a command's first cycle.
module ordered_list_engine_top #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_item_value,
  input  logic [7:0]         in_insert_position,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [CNT_W-1:0]   out_found_position,
  output logic [CNT_W-1:0]   out_list_length
);
  import ole_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  store_ctl_t       ctl;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    wr_idx;
  logic [31:0]      wr_data;
  logic [31:0]      rd_data;
  logic             done;
  status_t          status;
  logic [CNT_W-1:0] found;
  logic [CNT_W-1:0] len;

  logic             strobe_r;
  logic [2:0]       status_r;
  logic [CNT_W-1:0] found_r;
  logic [CNT_W-1:0] len_r;

  ole_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_item_value      (in_item_value),
    .in_insert_position (in_insert_position),
    .ctl                (ctl),
    .rd_idx             (rd_idx),
    .wr_idx             (wr_idx),
    .wr_data            (wr_data),
    .rd_data            (rd_data),
    .done               (done),
    .status             (status),
    .found              (found),
    .len                (len)
  );

  ole_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r <= status;
      found_r  <= found;
      len_r    <= len;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_list_length    = len_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_list_length <= CNT_W'(CAPACITY)))
    else $error("list length beyond capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FULL)) |-> (out_list_length == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_found_position != '0)) |-> (out_status == ST_DONE))
    else $error("position reported without success");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("command ended without result word");

  a_quick_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("command neither answered nor in progress");

endmodule

// ===== hw/rtl/ole_store.sv =====
// Entry memory of the list, kept as a ring with a head pointer.
module ole_store #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ole_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]      rd_idx,
  input  logic [AW-1:0]      wr_idx,
  input  logic [31:0]        wr_data,
  output logic [31:0]        rd_data
);
  import ole_pkg::*;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign rd_addr  = wrap_add(head_r, rd_idx);
  assign wr_addr  = wrap_add(head_r, wr_idx);
  assign head_nxt = ctl.pop_front ? wrap_add(head_r, AW'(1)) : head_r;
  assign rd_data  = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/ole_seq.sv =====
// Command sequencer: decode, entry count, shift and search walks.
module ole_seq #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic signed [31:0]  in_item_value,
  input  logic [7:0]          in_insert_position,
  output ole_pkg::store_ctl_t ctl,
  output logic [AW-1:0]       rd_idx,
  output logic [AW-1:0]       wr_idx,
  output logic [31:0]         wr_data,
  input  logic [31:0]         rd_data,
  output logic                done,
  output ole_pkg::status_t    status,
  output logic [CNT_W-1:0]    found,
  output logic [CNT_W-1:0]    len
);
  import ole_pkg::*;

  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_PUT    = 5'b01000,
    S_SEARCH = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      val_r, val_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;
  logic             pend_r, pend_nxt;
  logic             rd_go_r, rd_go_nxt;

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] n_plus1;
  logic             pos_bad;
  logic [AW-1:0]    last_idx;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign pos_ext  = CMP_W'(in_insert_position);
  assign n_plus1  = CMP_W'(cnt_r) + CMP_W'(1);
  assign pos_bad  = (in_insert_position == 8'd0) || (pos_ext > n_plus1);
  assign last_idx = AW'(cnt_r - CNT_W'(1));
  assign len      = cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    slot_nxt  = slot_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = 1'b0;
    rd_go_nxt = rd_go_r;
    ctl       = '0;
    rd_idx    = idx_r;
    wr_idx    = pidx_r;
    wr_data   = rd_data;
    done      = 1'b0;
    status    = ST_DONE;
    found     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_item_value;
          unique case (op_t'(in_opcode))
            OP_INSERT: begin
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                done   = 1'b1;
                status = ST_FULL;
              end else if (pos_bad) begin
                done   = 1'b1;
                status = ST_BAD_POS;
              end else if (pos_ext == n_plus1) begin
                ctl.wr_en = 1'b1;
                wr_idx    = AW'(cnt_r);
                wr_data   = in_item_value;
                cnt_nxt   = cnt_r + CNT_W'(1);
                done      = 1'b1;
              end else begin
                slot_nxt  = AW'(in_insert_position - 8'd1);
                idx_nxt   = last_idx;
                state_nxt = S_SHIFT;
              end
            end
            OP_DEL_REAR: begin
              done = 1'b1;
              if (cnt_r == '0) begin
                status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            OP_DEL_FRONT: begin
              done = 1'b1;
              if (cnt_r == '0) begin
                status = ST_EMPTY;
              end else begin
                ctl.pop_front = 1'b1;
                cnt_nxt       = cnt_r - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) begin
                done   = 1'b1;
                status = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                rd_go_nxt = 1'b1;
                state_nxt = S_SEARCH;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        ctl.rd_en = 1'b1;
        ctl.wr_en = pend_r;
        pend_nxt  = 1'b1;
        pidx_nxt  = idx_r + AW'(1);
        if (idx_r == slot_r) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_DRAIN: begin
        ctl.wr_en = pend_r;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        ctl.wr_en = 1'b1;
        wr_idx    = slot_r;
        wr_data   = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (rd_go_r) begin
          ctl.rd_en = 1'b1;
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r;
          if (idx_r == last_idx) begin
            rd_go_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (pend_r) begin
          if (rd_data == val_r) begin
            done      = 1'b1;
            found     = CNT_W'({1'b0, pidx_r} + (AW+1)'(1));
            state_nxt = S_IDLE;
          end else if (pidx_r == last_idx) begin
            done      = 1'b1;
            status    = ST_NOT_FOUND;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      rd_go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      rd_go_r <= rd_go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
  end

endmodule
